@@ rtl/cbpm_pkg.sv @@
`timescale 1ns / 1ps

package cbpm_pkg;

  localparam int unsigned CpuPages      = 8;
  localparam int unsigned CpuPageW      = 3;
  localparam int unsigned PpuPagesDef   = 12;
  localparam int unsigned OffsetBitsDef = 22;
  localparam int unsigned BankW         = 16;
  localparam int unsigned CountW        = 8;
  localparam int unsigned ApbAddrW      = 3;
  localparam int unsigned ApbDataW      = 32;

  localparam logic [CountW-1:0] PrgCountRst = 8'd2;
  localparam logic [CountW-1:0] ChrCountRst = 8'd1;

  typedef enum logic [2:0] {
    OP_MAP_PRG  = 3'd0,
    OP_MAP_CHR  = 3'd1,
    OP_MAP_VRAM = 3'd2,
    OP_RD_CPU   = 3'd3,
    OP_RD_PPU   = 3'd4
  } op_e;

  localparam logic [1:0] SizePrg8k  = 2'd0;
  localparam logic [1:0] SizePrg16k = 2'd1;
  localparam logic [1:0] SizePrg32k = 2'd2;
  localparam logic [1:0] SizeChr8k  = 2'd3;

  localparam logic [1:0] SrcPrgRom  = 2'd0;
  localparam logic [1:0] SrcChrRom  = 2'd1;
  localparam logic [1:0] SrcPatRam  = 2'd2;
  localparam logic [1:0] SrcNameRam = 2'd3;

  localparam logic RegPrgCount = 1'b0;
  localparam logic RegChrCount = 1'b1;

  typedef struct packed {
    logic [2:0]       opcode;
    logic [1:0]       size_code;
    logic [15:0]      address;
    logic [BankW-1:0] bank;
    logic             use_last_bank;
    logic [3:0]       page_number;
  } item_t;

  typedef struct packed {
    logic             map_ok;
    logic [BankW-1:0] bank;
  } bank_sel_t;

  typedef struct packed {
    logic       accepted;
    logic [1:0] source;
    logic       write_protect;
    logic       patterns_switched;
    logic       names_switched;
  } flags_t;

  // smear the highest set bit downwards
  function automatic logic [BankW-1:0] cover_mask(logic [BankW-1:0] top);
    logic [BankW-1:0] m;
    m = top;
    m = m | (m >> 1);
    m = m | (m >> 2);
    m = m | (m >> 4);
    m = m | (m >> 8);
    return m;
  endfunction

endpackage

@@ rtl/cbpm_if.sv @@
`timescale 1ns / 1ps

interface cbpm_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [1:0]  size_code;
  logic [15:0] address;
  logic [15:0] bank;
  logic        use_last_bank;
  logic [3:0]  page_number;

  modport source (
    output valid, opcode, size_code, address, bank, use_last_bank, page_number,
    input  ready
  );
  modport sink (
    input  valid, opcode, size_code, address, bank, use_last_bank, page_number,
    output ready
  );
endinterface

interface cbpm_rsp_if #(
  parameter int unsigned OFFSET_BITS = 22
);
  logic                   valid;
  logic                   ready;
  logic                   accepted;
  logic [1:0]             page_source;
  logic [OFFSET_BITS-1:0] offset;
  logic                   write_protect;
  logic                   patterns_switched;
  logic                   names_switched;

  modport source (
    output valid, accepted, page_source, offset, write_protect, patterns_switched,
           names_switched,
    input  ready
  );
  modport sink (
    input  valid, accepted, page_source, offset, write_protect, patterns_switched,
           names_switched,
    output ready
  );
endinterface

@@ rtl/cbpm_apb_regs.sv @@
`timescale 1ns / 1ps

module cbpm_apb_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [cbpm_pkg::ApbAddrW-1:0]  paddr,
  input  logic [cbpm_pkg::ApbDataW-1:0]  pwdata,
  output logic [cbpm_pkg::ApbDataW-1:0]  prdata,
  output logic                           pready,
  output logic [cbpm_pkg::CountW-1:0]    prg_count_o,
  output logic [cbpm_pkg::CountW-1:0]    chr_count_o
);
  import cbpm_pkg::*;

  logic              wr_en;
  logic              reg_idx;
  logic [CountW-1:0] prg_count_q, prg_count_d;
  logic [CountW-1:0] chr_count_q, chr_count_d;

  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[2];
  assign pready  = 1'b1;

  always_comb begin
    prg_count_d = prg_count_q;
    chr_count_d = chr_count_q;
    if (wr_en) begin
      case (reg_idx)
        RegPrgCount: prg_count_d = pwdata[CountW-1:0];
        RegChrCount: chr_count_d = pwdata[CountW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegPrgCount: prdata = ApbDataW'(prg_count_q);
      RegChrCount: prdata = ApbDataW'(chr_count_q);
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prg_count_q <= PrgCountRst;
      chr_count_q <= ChrCountRst;
    end else begin
      prg_count_q <= prg_count_d;
      chr_count_q <= chr_count_d;
    end
  end

  assign prg_count_o = prg_count_q;
  assign chr_count_o = chr_count_q;

endmodule

@@ rtl/cbpm_bank_check.sv @@
`timescale 1ns / 1ps

module cbpm_bank_check (
  input  cbpm_pkg::item_t               item_i,
  input  logic [cbpm_pkg::CountW-1:0]   prg_count_i,
  input  logic [cbpm_pkg::CountW-1:0]   chr_count_i,
  output cbpm_pkg::bank_sel_t           sel_o
);
  import cbpm_pkg::*;

  logic [BankW-1:0] n8, n1, m8, m1;
  logic [BankW-1:0] cnt, msk, pick;
  logic             size_ok;

  assign n8 = BankW'({prg_count_i, 1'b0});
  assign n1 = BankW'({chr_count_i, 3'b000});
  assign m8 = cover_mask(n8 - BankW'(1));
  assign m1 = cover_mask(n1 - BankW'(1));

  always_comb begin
    cnt     = '0;
    msk     = '0;
    size_ok = 1'b0;
    case (item_i.opcode)
      OP_MAP_PRG: begin
        case (item_i.size_code)
          SizePrg8k: begin
            cnt = n8;
            msk = m8;
            size_ok = 1'b1;
          end
          SizePrg16k: begin
            cnt = BankW'(prg_count_i);
            msk = m8 >> 1;
            size_ok = 1'b1;
          end
          SizePrg32k: begin
            cnt = BankW'(prg_count_i >> 1);
            msk = m8 >> 2;
            size_ok = 1'b1;
          end
          default: size_ok = 1'b0;
        endcase
      end
      OP_MAP_CHR: begin
        cnt     = n1 >> item_i.size_code;
        msk     = m1 >> item_i.size_code;
        size_ok = (chr_count_i != '0);
      end
      default: size_ok = 1'b0;
    endcase
  end

  assign pick = item_i.use_last_bank ? (cnt - BankW'(1)) : item_i.bank;

  always_comb begin
    sel_o.bank   = pick & msk;
    sel_o.map_ok = size_ok && !(item_i.use_last_bank && cnt == '0) && (sel_o.bank < cnt);
  end

endmodule

@@ rtl/cbpm_page_table.sv @@
`timescale 1ns / 1ps

module cbpm_page_table #(
  parameter int unsigned PPU_PAGES   = cbpm_pkg::PpuPagesDef,
  parameter int unsigned OFFSET_BITS = cbpm_pkg::OffsetBitsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   wr_en_i,
  input  cbpm_pkg::item_t        item_i,
  input  cbpm_pkg::bank_sel_t    sel_i,
  output cbpm_pkg::flags_t       flags_o,
  output logic [OFFSET_BITS-1:0] offset_o
);
  import cbpm_pkg::*;

  localparam int unsigned PpuIdxW = $clog2(PPU_PAGES);

  logic [OFFSET_BITS-1:0] cpu_off_q [CpuPages];
  logic [OFFSET_BITS-1:0] ppu_off_q [PPU_PAGES];
  logic [1:0]             ppu_src_q [PPU_PAGES];
  logic                   ppu_prot_q [PPU_PAGES];

  logic                   cpu_we [CpuPages];
  logic [OFFSET_BITS-1:0] cpu_wd [CpuPages];
  logic                   ppu_we [PPU_PAGES];
  logic [OFFSET_BITS-1:0] ppu_off_wd [PPU_PAGES];
  logic [1:0]             ppu_src_wd [PPU_PAGES];
  logic                   ppu_prot_wd [PPU_PAGES];

  logic [CpuPageW-1:0] cpu_page;
  logic [5:0]          ppu_start;
  logic                pn_in_ppu;
  logic                pn_pattern;
  logic                is_prg, is_chr, is_vram;

  assign cpu_page   = item_i.address[15:13];
  assign ppu_start  = (item_i.size_code == SizeChr8k) ? 6'd0 : item_i.address[15:10];
  assign pn_in_ppu  = ({1'b0, item_i.page_number} < 5'(PPU_PAGES));
  assign pn_pattern = !item_i.page_number[3];
  assign is_prg     = (item_i.opcode == OP_MAP_PRG)  && sel_i.map_ok;
  assign is_chr     = (item_i.opcode == OP_MAP_CHR)  && sel_i.map_ok;
  assign is_vram    = (item_i.opcode == OP_MAP_VRAM) && pn_in_ppu;

  always_comb begin
    logic [CpuPageW-1:0] jj;
    logic [31:0]         w;
    for (int j = 0; j < CpuPages; j++) begin
      jj = CpuPageW'(j);
      w  = '0;
      cpu_we[j] = 1'b0;
      case (item_i.size_code)
        SizePrg8k: begin
          cpu_we[j] = (jj == cpu_page);
          w = 32'(sel_i.bank) << 13;
        end
        SizePrg16k: begin
          cpu_we[j] = (jj == cpu_page) ||
                      ({1'b0, jj} == ({1'b0, cpu_page} + 4'd1));
          w = (32'(sel_i.bank) << 14) | ((jj == cpu_page) ? 32'h0 : 32'h2000);
        end
        SizePrg32k: begin
          cpu_we[j] = jj[2];
          w = (32'(sel_i.bank) << 15) | (32'(jj[1:0]) << 13);
        end
        default: cpu_we[j] = 1'b0;
      endcase
      cpu_we[j] = cpu_we[j] && is_prg && wr_en_i;
      cpu_wd[j] = w[OFFSET_BITS-1:0];
    end
  end

  always_comb begin
    logic [6:0]  diff;
    logic        in_run;
    logic [31:0] w;
    for (int j = 0; j < PPU_PAGES; j++) begin
      diff   = 7'(j) - {1'b0, ppu_start};
      in_run = (7'(j) >= {1'b0, ppu_start}) && (diff < (7'd1 << item_i.size_code));
      w      = (32'(sel_i.bank) << (5'd10 + 5'(item_i.size_code))) |
               (32'(diff[2:0]) << 10);
      if (is_vram) begin
        ppu_we[j]      = (4'(j) == item_i.page_number) && wr_en_i;
        ppu_off_wd[j]  = pn_pattern ? OFFSET_BITS'({item_i.bank[3:0], 10'b0})
                                    : OFFSET_BITS'({item_i.bank[1:0], 10'b0});
        ppu_src_wd[j]  = pn_pattern ? SrcPatRam : SrcNameRam;
        ppu_prot_wd[j] = 1'b0;
      end else begin
        ppu_we[j]      = is_chr && in_run && wr_en_i;
        ppu_off_wd[j]  = w[OFFSET_BITS-1:0];
        ppu_src_wd[j]  = SrcChrRom;
        ppu_prot_wd[j] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < CpuPages; j++) begin
      if (cpu_we[j]) begin
        cpu_off_q[j] <= cpu_wd[j];
      end
    end
    for (int j = 0; j < PPU_PAGES; j++) begin
      if (ppu_we[j]) begin
        ppu_off_q[j] <= ppu_off_wd[j];
        ppu_src_q[j] <= ppu_src_wd[j];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < PPU_PAGES; j++) begin
        ppu_prot_q[j] <= 1'b0;
      end
    end else begin
      for (int j = 0; j < PPU_PAGES; j++) begin
        if (ppu_we[j]) begin
          ppu_prot_q[j] <= ppu_prot_wd[j];
        end
      end
    end
  end

  always_comb begin
    flags_o  = '0;
    offset_o = '0;
    case (item_i.opcode)
      OP_MAP_PRG: flags_o.accepted = sel_i.map_ok;
      OP_MAP_CHR: begin
        flags_o.accepted          = sel_i.map_ok;
        flags_o.patterns_switched = sel_i.map_ok;
      end
      OP_MAP_VRAM: begin
        flags_o.accepted          = pn_in_ppu;
        flags_o.patterns_switched = pn_in_ppu && pn_pattern;
        flags_o.names_switched    = pn_in_ppu && !pn_pattern;
      end
      OP_RD_CPU: begin
        if (!item_i.page_number[3]) begin
          flags_o.accepted = 1'b1;
          offset_o = cpu_off_q[item_i.page_number[CpuPageW-1:0]];
        end
      end
      OP_RD_PPU: begin
        if (pn_in_ppu) begin
          flags_o.accepted      = 1'b1;
          flags_o.source        = ppu_src_q[item_i.page_number[PpuIdxW-1:0]];
          flags_o.write_protect = ppu_prot_q[item_i.page_number[PpuIdxW-1:0]];
          offset_o = ppu_off_q[item_i.page_number[PpuIdxW-1:0]];
        end
      end
      default: ;
    endcase
  end

endmodule

@@ rtl/cartridge_bank_page_mapper_top.sv @@
`timescale 1ns / 1ps
// A request is registered in the request register and its result in the
// result register. One request per cycle while the response is not stalled;
// the page table is read and written between the two registers.
// Reset: asynchronous, active low; clears control state, write-protect bits
// and loads the default ROM unit counts.

module cartridge_bank_page_mapper_top #(
  parameter int unsigned PPU_PAGES   = cbpm_pkg::PpuPagesDef,
  parameter int unsigned OFFSET_BITS = cbpm_pkg::OffsetBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  cbpm_req_if.sink                      req_i,
  cbpm_rsp_if.source                    rsp_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cbpm_pkg::ApbAddrW-1:0] paddr,
  input  logic [cbpm_pkg::ApbDataW-1:0] pwdata,
  output logic [cbpm_pkg::ApbDataW-1:0] prdata,
  output logic                          pready
);
  import cbpm_pkg::*;

  logic [CountW-1:0] prg_count, chr_count;

  item_t     item_q, item_d;
  logic      s1_valid_q, s1_valid_d;
  logic      s2_valid_q, s2_valid_d;
  flags_t    flags_q, flags_d;
  logic [OFFSET_BITS-1:0] offset_q, offset_d;
  bank_sel_t bank_sel;

  logic req_xfer, s2_free, s1_adv;

  cbpm_apb_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .prg_count_o (prg_count),
    .chr_count_o (chr_count)
  );

  cbpm_bank_check u_bank (
    .item_i      (item_q),
    .prg_count_i (prg_count),
    .chr_count_i (chr_count),
    .sel_o       (bank_sel)
  );

  cbpm_page_table #(
    .PPU_PAGES   (PPU_PAGES),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (s1_adv),
    .item_i   (item_q),
    .sel_i    (bank_sel),
    .flags_o  (flags_d),
    .offset_o (offset_d)
  );

  assign s2_free     = !s2_valid_q || rsp_o.ready;
  assign s1_adv      = s1_valid_q && s2_free;
  assign req_i.ready = !s1_valid_q || s2_free;
  assign req_xfer    = req_i.valid && req_i.ready;

  assign s1_valid_d = req_xfer || (s1_valid_q && !s1_adv);
  assign s2_valid_d = s1_adv || (s2_valid_q && !rsp_o.ready);

  always_comb begin
    item_d.opcode        = req_i.opcode;
    item_d.size_code     = req_i.size_code;
    item_d.address       = req_i.address;
    item_d.bank          = req_i.bank;
    item_d.use_last_bank = req_i.use_last_bank;
    item_d.page_number   = req_i.page_number;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_xfer) begin
      item_q <= item_d;
    end
    if (s1_adv) begin
      flags_q  <= flags_d;
      offset_q <= offset_d;
    end
  end

  assign rsp_o.valid             = s2_valid_q;
  assign rsp_o.accepted          = flags_q.accepted;
  assign rsp_o.page_source       = flags_q.source;
  assign rsp_o.offset            = offset_q;
  assign rsp_o.write_protect     = flags_q.write_protect;
  assign rsp_o.patterns_switched = flags_q.patterns_switched;
  assign rsp_o.names_switched    = flags_q.names_switched;

endmodule

@@ rtl/cbpm_checker.sv @@
`timescale 1ns / 1ps

module cbpm_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic       rsp_accepted,
  input logic [1:0] rsp_source,
  input logic       rsp_write_protect,
  input logic       rsp_patterns_switched,
  input logic       rsp_names_switched,
  input logic       pready
);
  import cbpm_pkg::*;

  // hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_accepted) &&
      $stable(rsp_source) && $stable(rsp_write_protect))
    else $error("stalled result changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid |-> !(rsp_patterns_switched && rsp_names_switched))
    else $error("pattern and nametable pulses together");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_accepted |-> !rsp_patterns_switched && !rsp_names_switched &&
      !rsp_write_protect && rsp_source == SrcPrgRom)
    else $error("dropped transfer carries data");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && rsp_write_protect |-> rsp_source == SrcChrRom)
    else $error("write protect on a RAM page");

  assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind cartridge_bank_page_mapper_top cbpm_checker u_cbpm_checker (
  .clk_i                 (clk_i),
  .rst_ni                (rst_ni),
  .rsp_valid             (rsp_o.valid),
  .rsp_ready             (rsp_o.ready),
  .rsp_accepted          (rsp_o.accepted),
  .rsp_source            (rsp_o.page_source),
  .rsp_write_protect     (rsp_o.write_protect),
  .rsp_patterns_switched (rsp_o.patterns_switched),
  .rsp_names_switched    (rsp_o.names_switched),
  .pready                (pready)
);
